// File: hdl/ohc_pkg.sv
`default_nettype none

package ohc_pkg;

  // Sample width of the gravity inputs
  localparam int SAMPLE_BITS = 16;
  // Squared magnitude of a sample vector, x^2 + y^2
  localparam int MAG2_W = 2 * SAMPLE_BITS;
  localparam int MIN_TILT_W = 15;
  localparam int LIM2_W = 2 * MIN_TILT_W;
  localparam int CMP_W = (MAG2_W > LIM2_W) ? MAG2_W : LIM2_W;

  // tan(55 deg) approximated as TAN55_NUM / 2^TAN55_SHIFT
  localparam int TAN55_SHIFT = 12;
  localparam int TAN55_NUM_W = 13;
  localparam logic [TAN55_NUM_W-1:0] TAN55_NUM = 13'd5850;
  localparam int TAN_W = SAMPLE_BITS + TAN55_NUM_W;

  localparam int AGREE_W = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    HOLD_RIGHT = 2'd0,
    HOLD_LEFT  = 2'd1,
    HOLD_TALL  = 2'd2
  } hold_t;

  typedef enum logic [1:0] {
    REG_AUTO_MODE    = 2'd0,
    REG_FIXED_HOLD   = 2'd1,
    REG_MIN_TILT     = 2'd2,
    REG_AGREE_NEEDED = 2'd3
  } reg_idx_t;

  localparam logic                  AUTO_MODE_RST    = 1'b1;
  localparam logic [1:0]            FIXED_HOLD_RST   = 2'd2;
  localparam logic [MIN_TILT_W-1:0] MIN_TILT_RST     = 15'd1434;
  localparam logic [AGREE_W-1:0]    AGREE_NEEDED_RST = 4'd6;

  // Joystick rotation for each hold
  function automatic logic [1:0] quarter_turns(input hold_t h);
    logic [1:0] q;
    case (h)
      HOLD_RIGHT: q = 2'd2;
      HOLD_LEFT:  q = 2'd0;
      default:    q = 2'd3;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// File: hdl/orientation_hold_classifier.sv
// Orientation hold classifier: portrait / landscape decision from accelerometer samples.
// Input channel (in_valid/in_ready): one sample per transfer, grav_x, grav_y and the
// sensor-ok flag. Result channel (out_valid/out_ready): exactly one result per sample,
// the hold after that sample, its tall flag, the joystick quarter turns, whether the
// hold changed on this sample, and whether a first verdict or fixed mode has primed it.
// Pipeline: input register, product stage (squares, tan-55 compare), then the
// classify / hysteresis update into the result register. One sample per cycle is
// sustained while out_ready holds, set by the single hysteresis state update per cycle.
// When the receiver stalls, the result register holds and the earlier stages keep
// filling until each holds an item; in_ready drops only when all three are full.
// Reset (synchronous, rst_n low) empties the pipeline, clears the hold state
// (right landscape, not primed, filter cleared) and restores the register defaults:
// auto mode, fixed hold tall, min tilt 1434, agree_needed six.
// Registers over the APB port at byte 0/4/8/12: auto_mode, fixed_hold, min_tilt,
// agree_needed. Writes are meant for idle periods only.
`default_nettype none

module orientation_hold_classifier (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [ohc_pkg::SAMPLE_BITS-1:0] in_grav_x,
  input  wire logic signed [ohc_pkg::SAMPLE_BITS-1:0] in_grav_y,
  input  wire logic                                 in_sensor_ok,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                out_hold,
  output logic                                      out_tall_hold,
  output logic [1:0]                                out_input_quarter_turns,
  output logic                                      out_rotation_applied,
  output logic                                      out_hold_primed,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ohc_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [ohc_pkg::PDATA_W-1:0]          pwdata,
  output logic [ohc_pkg::PDATA_W-1:0]               prdata,
  output logic                                      pready
);

  localparam int SB = ohc_pkg::SAMPLE_BITS;

  // Configuration
  logic                             auto_mode_r;
  logic [1:0]                       fixed_hold_r;
  logic [ohc_pkg::MIN_TILT_W-1:0]   min_tilt_r;
  logic [ohc_pkg::AGREE_W-1:0]      agree_needed_r;
  ohc_pkg::reg_idx_t                reg_sel;
  logic                             cfg_wr;

  // Stage 1: input register
  logic                 s1_valid_r;
  logic signed [SB-1:0] s1_x_r;
  logic signed [SB-1:0] s1_y_r;
  logic                 s1_ok_r;

  // Stage 2: products and sector bits
  logic                          s2_valid_r;
  logic [ohc_pkg::MAG2_W-1:0]    s2_mag2_r;
  logic [ohc_pkg::LIM2_W-1:0]    s2_lim2_r;
  logic                          s2_ign_r;
  logic                          s2_yneg_r;
  logic                          s2_tall_pos_r;
  logic                          s2_tall_neg_r;
  logic                          s2_ok_r;

  // Hold state
  ohc_pkg::hold_t               cur_hold_r, cur_hold_nxt;
  ohc_pkg::hold_t               pend_hold_r, pend_hold_nxt;
  logic                         primed_r, primed_nxt;
  logic [ohc_pkg::AGREE_W-1:0]  agree_cnt_r, agree_cnt_nxt;

  // Result register
  logic                 out_valid_r;
  ohc_pkg::hold_t       out_hold_r;
  logic                 out_tall_r;
  logic [1:0]           out_qt_r;
  logic                 out_rot_r;
  logic                 out_primed_r;

  // Handshake / flow control
  logic o_free, s2_free, s1_free, s2_adv, s1_adv, in_xfer;

  assign o_free   = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && o_free;
  assign s2_free  = !s2_valid_r || o_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign in_xfer  = in_valid && in_ready;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_sel = ohc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      ohc_pkg::REG_AUTO_MODE:    prdata[0] = auto_mode_r;
      ohc_pkg::REG_FIXED_HOLD:   prdata[1:0] = fixed_hold_r;
      ohc_pkg::REG_MIN_TILT:     prdata[ohc_pkg::MIN_TILT_W-1:0] = min_tilt_r;
      ohc_pkg::REG_AGREE_NEEDED: prdata[ohc_pkg::AGREE_W-1:0] = agree_needed_r;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r    <= ohc_pkg::AUTO_MODE_RST;
      fixed_hold_r   <= ohc_pkg::FIXED_HOLD_RST;
      min_tilt_r     <= ohc_pkg::MIN_TILT_RST;
      agree_needed_r <= ohc_pkg::AGREE_NEEDED_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ohc_pkg::REG_AUTO_MODE:    auto_mode_r <= pwdata[0];
        ohc_pkg::REG_FIXED_HOLD:   fixed_hold_r <= pwdata[1:0];
        ohc_pkg::REG_MIN_TILT:     min_tilt_r <= pwdata[ohc_pkg::MIN_TILT_W-1:0];
        ohc_pkg::REG_AGREE_NEEDED: agree_needed_r <= pwdata[ohc_pkg::AGREE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1 -> stage 2 ----------------
  logic signed [SB:0]         x_ext, y_ext, x_abs, y_abs;
  logic [SB-1:0]              ax, ay;
  logic [ohc_pkg::MAG2_W-1:0] ax2, ay2;
  logic [ohc_pkg::TAN_W-1:0]  ay_scaled, ax_scaled;

  always_comb begin
    x_ext     = {s1_x_r[SB-1], s1_x_r};
    y_ext     = {s1_y_r[SB-1], s1_y_r};
    x_abs     = x_ext[SB] ? -x_ext : x_ext;
    y_abs     = y_ext[SB] ? -y_ext : y_ext;
    ax        = x_abs[SB-1:0];
    ay        = y_abs[SB-1:0];
    ax2       = ohc_pkg::MAG2_W'(ax) * ohc_pkg::MAG2_W'(ax);
    ay2       = ohc_pkg::MAG2_W'(ay) * ohc_pkg::MAG2_W'(ay);
    ay_scaled = ohc_pkg::TAN_W'(ay) << ohc_pkg::TAN55_SHIFT;
    ax_scaled = ohc_pkg::TAN_W'(ax) * ohc_pkg::TAN_W'(ohc_pkg::TAN55_NUM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_valid;
      if (s2_free) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r  <= in_grav_x;
      s1_y_r  <= in_grav_y;
      s1_ok_r <= in_sensor_ok;
    end
    if (s1_adv) begin
      s2_mag2_r     <= ax2 + ay2;
      s2_lim2_r     <= ohc_pkg::LIM2_W'(min_tilt_r) * ohc_pkg::LIM2_W'(min_tilt_r);
      // within 55 deg of 180 deg; the boundary itself is not ignored
      s2_ign_r      <= x_ext[SB] && (ay_scaled < ax_scaled);
      s2_yneg_r     <= y_ext[SB];
      s2_tall_pos_r <= x_ext > y_ext;
      s2_tall_neg_r <= x_ext > -y_ext;
      s2_ok_r       <= s1_ok_r;
    end
  end

  // ---------------- stage 2 -> result: classify and hysteresis ----------------
  logic           flat, verdict_ok;
  ohc_pkg::hold_t verdict, fixed_sat;

  always_comb begin
    flat = ohc_pkg::CMP_W'(s2_mag2_r) < ohc_pkg::CMP_W'(s2_lim2_r);
    verdict_ok = s2_ok_r && !flat && !s2_ign_r;
    if (s2_yneg_r) begin
      verdict = s2_tall_neg_r ? ohc_pkg::HOLD_TALL : ohc_pkg::HOLD_LEFT;
    end else begin
      verdict = s2_tall_pos_r ? ohc_pkg::HOLD_TALL : ohc_pkg::HOLD_RIGHT;
    end
    // unused code 3 saturates to tall
    fixed_sat = (fixed_hold_r > 2'(ohc_pkg::HOLD_TALL)) ? ohc_pkg::HOLD_TALL
                                                        : ohc_pkg::hold_t'(fixed_hold_r);
  end

  always_comb begin
    cur_hold_nxt  = cur_hold_r;
    pend_hold_nxt = pend_hold_r;
    primed_nxt    = primed_r;
    agree_cnt_nxt = agree_cnt_r;
    if (!auto_mode_r) begin
      cur_hold_nxt = fixed_sat;
      primed_nxt   = 1'b1;
    end else if (verdict_ok) begin
      if (!primed_r) begin
        primed_nxt   = 1'b1;
        cur_hold_nxt = verdict;
      end else begin
        if (verdict == pend_hold_r) begin
          if (agree_cnt_r < agree_needed_r) agree_cnt_nxt = agree_cnt_r + 1'b1;
        end else begin
          pend_hold_nxt = verdict;
          agree_cnt_nxt = '0;
        end
        if (agree_cnt_nxt >= agree_needed_r && cur_hold_r != pend_hold_nxt) begin
          cur_hold_nxt = pend_hold_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_hold_r  <= ohc_pkg::HOLD_RIGHT;
      pend_hold_r <= ohc_pkg::HOLD_RIGHT;
      primed_r    <= 1'b0;
      agree_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        cur_hold_r  <= cur_hold_nxt;
        pend_hold_r <= pend_hold_nxt;
        primed_r    <= primed_nxt;
        agree_cnt_r <= agree_cnt_nxt;
      end
      if (o_free) out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_hold_r   <= cur_hold_nxt;
      out_tall_r   <= cur_hold_nxt == ohc_pkg::HOLD_TALL;
      out_qt_r     <= ohc_pkg::quarter_turns(cur_hold_nxt);
      out_rot_r    <= cur_hold_nxt != cur_hold_r;
      out_primed_r <= primed_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_hold                = out_hold_r;
  assign out_tall_hold           = out_tall_r;
  assign out_input_quarter_turns = out_qt_r;
  assign out_rotation_applied    = out_rot_r;
  assign out_hold_primed         = out_primed_r;

  // ---------------- assertions ----------------
  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped without reset");

  a_hold_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_adv |=> $stable(cur_hold_r) && $stable(agree_cnt_r) && $stable(pend_hold_r))
    else $error("hold state changed without a sample leaving stage 2");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty result register");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_hold_r == cur_hold_r && out_primed_r == primed_r)
    else $error("result register disagrees with hold state");

endmodule

`default_nettype wire
